/* src/pps_time_reference_tracker_defines.svh */
// Assertion macros shared by the time reference tracker.
`ifndef PPS_TIME_REFERENCE_TRACKER_DEFINES_SVH
`define PPS_TIME_REFERENCE_TRACKER_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define PPTR_ASSERT_SAME(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// The condition must hold in the cycle after the trigger.
`define PPTR_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

/* src/pptr_pkg.sv */
`default_nettype none

package pptr_pkg;

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_HARD_PPS   = 2'd0,
    OP_SOFT_PPS   = 2'd1,
    OP_CORRECTION = 2'd2,
    OP_QUERY      = 2'd3
  } pptr_op_t;

  localparam int unsigned QUOT_W = 23;   // floor((2^32 - 1) / 1000) fits in 23 bits
  localparam int unsigned MS_W   = 10;

  localparam logic [31:0] MS_PER_SEC = 32'd1000;
  localparam logic [31:0] HALF_SEC   = 32'd500;

  // Reciprocal of 125 scaled by 2^36, exact for 29-bit numerators.
  localparam logic [29:0] RECIP_125   = 30'd549755814;
  localparam int unsigned RECIP_SHIFT = 36;

  // Soft PPS pull: floor((residual + 8) / 16) with residual = rem - 500.
  localparam logic signed [10:0] PULL_BIAS  = 11'sd492;
  localparam int unsigned        PULL_SHIFT = 4;

  typedef struct packed {
    pptr_op_t           op;
    logic [31:0]        tick;
    logic [31:0]        gps_seconds;
    logic signed [31:0] offset_ms;
    logic signed [15:0] correction;
  } pptr_item_t;

  typedef struct packed {
    logic [31:0]     seconds;
    logic [MS_W-1:0] millis;
    logic [31:0]     ref_tick_out;
    logic [31:0]     ref_seconds_out;
  } pptr_result_t;

endpackage

`default_nettype wire

/* src/pps_time_reference_tracker.sv */
`default_nettype none
`include "pps_time_reference_tracker_defines.svh"

// Keeps a reference millisecond tick and the whole-second time at that tick,
// disciplined by hard and soft PPS beats and nudged by correction beats; every
// input beat yields one result beat with the seconds and milliseconds at its
// own tick after the update. The block takes one beat per clock cycle while
// item_stall is low. A beat passes through the input register and the middle
// stage into the result register. The reference state is updated through one
// 29 x 30 bit reciprocal multiply (division by 1000) as a beat leaves the
// input register; a second divide stage then forms the reported time. A
// stalled output holds its result while the input register and the middle
// stage still fill.
module pps_time_reference_tracker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  pptr_pkg::pptr_item_t   item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output pptr_pkg::pptr_result_t result
);
  import pptr_pkg::*;

  pptr_item_t   s1;
  logic         s1_valid;
  logic [31:0]  s2_tick;
  logic         s2_valid;
  logic [31:0]  ref_tick;
  logic [31:0]  ref_seconds;
  logic [31:0]  ref_tick_next;
  logic [31:0]  ref_seconds_next;
  pptr_result_t result_next;

  logic out_ready;
  logic s2_ready;
  logic s2_move;
  logic s1_move;

  logic [31:0]        offset_u;
  logic [31:0]        event_tick;
  logic [31:0]        div_base;
  logic [31:0]        elapsed;
  logic [QUOT_W-1:0]  step_quot;
  logic [MS_W-1:0]    step_rem;
  logic signed [10:0] pull_biased;
  logic signed [10:0] pull_small;
  logic [31:0]        pull;
  logic [31:0]        corr_ext;

  logic [31:0]       delta;
  logic [QUOT_W-1:0] out_quot;
  logic [MS_W-1:0]   out_rem;

  // Pipeline flow control: each stage moves when the next one is free.
  assign out_ready  = !result_valid || !result_stall;
  assign s2_move    = s2_valid && out_ready;
  assign s2_ready   = !s2_valid || out_ready;
  assign s1_move    = s1_valid && s2_ready;
  assign item_stall = s1_valid && !s2_ready;

  // Rounded whole seconds from the reference to the event tick (soft PPS) or to the beat's tick.
  assign offset_u   = s1.offset_ms;
  assign event_tick = s1.tick - offset_u;
  assign div_base   = (s1.op == OP_SOFT_PPS) ? event_tick : s1.tick;
  assign elapsed    = div_base - ref_tick + HALF_SEC;

  pptr_div1000 u_step_div (
    .dividend  (elapsed),
    .quotient  (step_quot),
    .remainder (step_rem)
  );

  // The soft PPS residual after whole-second steps is rem - 500, so the new
  // reference is event + 500 - rem plus the rounded sixteenth of the residual.
  assign pull_biased = $signed({1'b0, step_rem}) - PULL_BIAS;
  assign pull_small  = pull_biased >>> PULL_SHIFT;
  assign pull        = {{21{pull_small[10]}}, pull_small};
  assign corr_ext    = {{16{s1.correction[15]}}, s1.correction};

  // Reference state update for the beat leaving the input register.
  always_comb begin
    ref_tick_next    = ref_tick;
    ref_seconds_next = ref_seconds;
    case (s1.op)
      OP_HARD_PPS: begin
        ref_seconds_next = ref_seconds + 32'(step_quot);
        ref_tick_next    = s1.tick;
      end
      OP_SOFT_PPS: begin
        ref_seconds_next = s1.gps_seconds;
        ref_tick_next    = event_tick + HALF_SEC - 32'(step_rem) + pull;
      end
      OP_CORRECTION: begin
        ref_tick_next = ref_tick + corr_ext;
      end
      OP_QUERY: begin
        ref_tick_next = ref_tick;
      end
      default: begin
        ref_tick_next = ref_tick;
      end
    endcase
  end

  // The reference registers change only as a beat enters the middle stage,
  // so while that stage holds a beat they hold exactly its updated state.
  assign delta = s2_tick + MS_PER_SEC - ref_tick;

  pptr_div1000 u_time_div (
    .dividend  (delta),
    .quotient  (out_quot),
    .remainder (out_rem)
  );

  // Reported time of day at the beat's own tick.
  always_comb begin
    result_next.seconds         = ref_seconds - 32'd1 + 32'(out_quot);
    result_next.millis          = out_rem;
    result_next.ref_tick_out    = ref_tick;
    result_next.ref_seconds_out = ref_seconds;
  end

  // Control and reference state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
      ref_tick     <= '0;
      ref_seconds  <= '0;
    end else begin
      if (!item_stall) begin
        s1_valid <= item_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (out_ready) begin
        result_valid <= s2_valid;
      end
      if (s1_move) begin
        ref_tick    <= ref_tick_next;
        ref_seconds <= ref_seconds_next;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (!item_stall) begin
      s1 <= item;
    end
    if (s1_move) begin
      s2_tick <= s1.tick;
    end
    if (s2_move) begin
      result <= result_next;
    end
  end

  // Checks on the design's own logic.
  `PPTR_ASSERT_SAME(a_millis_range, clk, rst, result_valid, result.millis < 10'd1000, "Millisecond field out of range")
  `PPTR_ASSERT_NEXT(a_state_hold, clk, rst, !s1_move, $stable(ref_tick) && $stable(ref_seconds), "Reference state changed without a beat")
  `PPTR_ASSERT_NEXT(a_hard_ref, clk, rst, s1_move && (s1.op == OP_HARD_PPS), ref_tick == $past(s1.tick), "Hard PPS did not move the reference tick")

endmodule

`default_nettype wire

/* src/pptr_div1000.sv */
`default_nettype none

module pptr_div1000 (
  input  logic [31:0]               dividend,
  output logic [pptr_pkg::QUOT_W-1:0] quotient,
  output logic [pptr_pkg::MS_W-1:0]   remainder
);
  import pptr_pkg::*;

  logic [28:0] eighths;
  logic [58:0] product;
  logic [31:0] quot_ext;
  logic [31:0] quot_times_k;
  logic [31:0] rem_full;

  // Divide by 8 with a shift, then by 125 with a reciprocal multiply.
  assign eighths  = dividend[31:3];
  assign product  = 59'(eighths) * 59'(RECIP_125);
  assign quotient = product[RECIP_SHIFT +: QUOT_W];

  // Remainder from the quotient: 1000 = 1024 - 16 - 8.
  assign quot_ext     = 32'(quotient);
  assign quot_times_k = (quot_ext << 10) - (quot_ext << 4) - (quot_ext << 3);
  assign rem_full     = dividend - quot_times_k;
  assign remainder    = rem_full[MS_W-1:0];

endmodule

`default_nettype wire
